// ----- src/rgb_led_pulse_code_encoder_top_defines.svh -----
// Assertion macros for the RGB LED pulse-code encoder.
// Used by the top level; depends on nothing else.
`ifndef RGB_LED_PULSE_CODE_ENCODER_TOP_DEFINES_SVH
`define RGB_LED_PULSE_CODE_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RLPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RLPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rlpc_pkg.sv -----
// Shared constants, types and the tangent factor table of the pulse-code encoder.
// Depends on nothing; used by every module of the block.
package rlpc_pkg;

  localparam int unsigned SCALE_FRAC_BITS_DEF = 16;
  localparam int unsigned TOP_BIT             = 23;
  localparam int unsigned COLOR_W             = TOP_BIT + 1;

  localparam logic [1:0] CODE_ONE  = 2'd3;
  localparam logic [1:0] CODE_ZERO = 2'd2;
  localparam logic [1:0] CODE_GAP  = 2'd0;

  localparam logic [7:0] DEFAULT_GAP    = 8'd50;
  localparam logic [5:0] MAX_ANGLE      = 6'd45;
  localparam logic [4:0] LAST_DATA_SLOT = 5'd23;
  localparam logic [4:0] GAP_SLOT       = 5'd24;

  typedef enum logic [1:0] {
    CFG_SCALE_ENABLE = 2'd0,
    CFG_BRIGHTNESS   = 2'd1,
    CFG_RESET_SLOTS  = 2'd2
  } cfg_idx_e;

  // One pixel handed to the serializer: packed GRB word and the frame mark.
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  // Serializer status seen by the input stage.
  typedef struct packed {
    logic busy;
    logic free;
  } ser_stat_t;

  // tan(b degrees) in unsigned Q1.16, rounded to nearest. Angles above the
  // maximum saturate to unity.
  function automatic logic [16:0] tan_q16(input logic [5:0] b);
    logic [16:0] t;
    case (b)
      6'd0:  t = 17'd0;
      6'd1:  t = 17'd1144;
      6'd2:  t = 17'd2289;
      6'd3:  t = 17'd3435;
      6'd4:  t = 17'd4583;
      6'd5:  t = 17'd5734;
      6'd6:  t = 17'd6888;
      6'd7:  t = 17'd8047;
      6'd8:  t = 17'd9210;
      6'd9:  t = 17'd10380;
      6'd10: t = 17'd11556;
      6'd11: t = 17'd12739;
      6'd12: t = 17'd13930;
      6'd13: t = 17'd15130;
      6'd14: t = 17'd16340;
      6'd15: t = 17'd17560;
      6'd16: t = 17'd18792;
      6'd17: t = 17'd20036;
      6'd18: t = 17'd21294;
      6'd19: t = 17'd22566;
      6'd20: t = 17'd23853;
      6'd21: t = 17'd25157;
      6'd22: t = 17'd26478;
      6'd23: t = 17'd27818;
      6'd24: t = 17'd29179;
      6'd25: t = 17'd30560;
      6'd26: t = 17'd31964;
      6'd27: t = 17'd33392;
      6'd28: t = 17'd34846;
      6'd29: t = 17'd36327;
      6'd30: t = 17'd37837;
      6'd31: t = 17'd39378;
      6'd32: t = 17'd40951;
      6'd33: t = 17'd42560;
      6'd34: t = 17'd44205;
      6'd35: t = 17'd45889;
      6'd36: t = 17'd47615;
      6'd37: t = 17'd49385;
      6'd38: t = 17'd51202;
      6'd39: t = 17'd53070;
      6'd40: t = 17'd54991;
      6'd41: t = 17'd56970;
      6'd42: t = 17'd59009;
      6'd43: t = 17'd61113;
      6'd44: t = 17'd63287;
      default: t = 17'd65536;
    endcase
    return t;
  endfunction

  // Moves a Q1.16 factor to frac fractional bits: a left shift when widening,
  // round half up when narrowing.
  function automatic logic [31:0] aligned_factor(input logic [16:0] t,
                                                 input int unsigned frac);
    logic [31:0] w;
    int unsigned dn;
    w = {15'd0, t};
    dn = 0;
    if (frac >= 16) begin
      return w << (frac - 16);
    end else begin
      dn = 16 - frac;
      return (w + (32'd1 << (dn - 1))) >> dn;
    end
  endfunction

endpackage

// ----- src/rlpc_scaler.sv -----
// One color channel scaled by tan(brightness), truncated and saturated to a byte.
// Depends on rlpc_pkg for the factor table and alignment.
module rlpc_scaler import rlpc_pkg::*; #(
  parameter int unsigned ScaleFracBits = SCALE_FRAC_BITS_DEF
) (
  input  logic [7:0] chan_i,
  input  logic [5:0] bright_i,
  output logic [7:0] chan_o
);

  localparam int unsigned FactW = ScaleFracBits + 1;
  localparam int unsigned ProdW = FactW + 8;

  logic [FactW-1:0] factor;
  logic [ProdW-1:0] prod;
  logic [8:0]       whole;

  assign factor = FactW'(aligned_factor(tan_q16(bright_i), ScaleFracBits));
  assign prod   = ProdW'(chan_i) * ProdW'(factor);
  assign whole  = prod[ProdW-1:ScaleFracBits];
  assign chan_o = whole[8] ? 8'hFF : whole[7:0];

endmodule

// ----- src/rlpc_serializer.sv -----
// Result stage: shifts a GRB word out as 24 duty codes, then the latch gap if marked.
// Depends on rlpc_pkg for codes, slot limits and the pixel and status types.
module rlpc_serializer import rlpc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  pixel_t     pixel_i,
  input  logic [7:0] gap_len_i,
  output ser_stat_t  stat_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] duty_code_o,
  output logic [7:0] repeat_count_o,
  output logic       frame_end_o
);

  logic               busy_q;
  logic [COLOR_W-1:0] color_q;
  logic               last_q;
  logic [4:0]         slot_q;
  logic               is_gap;
  logic               final_slot;
  logic               take;

  assign is_gap     = (slot_q == GAP_SLOT);
  assign final_slot = is_gap || ((slot_q == LAST_DATA_SLOT) && !last_q);
  assign take       = busy_q && out_ready_i;

  assign out_valid_o    = busy_q;
  assign duty_code_o    = is_gap ? CODE_GAP : (color_q[COLOR_W-1] ? CODE_ONE : CODE_ZERO);
  assign repeat_count_o = is_gap ? gap_len_i : 8'd1;
  assign frame_end_o    = is_gap;

  assign stat_o.busy = busy_q;
  assign stat_o.free = !busy_q || (take && final_slot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      slot_q <= '0;
    end else if (take) begin
      if (final_slot) begin
        busy_q <= 1'b0;
      end else begin
        slot_q <= slot_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      color_q <= pixel_i.color;
      last_q  <= pixel_i.last;
    end else if (take) begin
      color_q <= {color_q[COLOR_W-2:0], 1'b0};
    end
  end

endmodule

// ----- src/rgb_led_pulse_code_encoder_top.sv -----
// Top level of the RGB LED pulse-code encoder: configuration registers, input
// register, three channel scalers and the serializer. Depends on rlpc_pkg,
// rlpc_scaler, rlpc_serializer and the assertion macro header.
//
//  Channel  Direction  Handshake                 Payload
//  -------  ---------  ------------------------  ----------------------------------
//  in       sink       in_valid_i / in_ready_o   red_i, green_i, blue_i, last_pixel_i
//  out      source     out_valid_o / out_ready_i duty_code_o, repeat_count_o,
//                                                frame_end_o
//  cfg      sink       cfg_we_i (no wait)        cfg_index_i, cfg_wdata_i
//
// A pixel gives 24 results, or 25 when it is marked last; the serializer
// emits one result per cycle while the output is ready, and it loads the next
// pixel as the final result of the one before is taken, so no bubble forms.
// A request sits in the input register, is scaled on its way into the
// serializer, and the next request is accepted while the current one shifts out.
// Reset clears valid flags and loads the register defaults; there is no clearing pass.
// A stalled output holds the current code; the input stalls only when both the
// input register and the serializer are occupied.
`include "rgb_led_pulse_code_encoder_top_defines.svh"

module rgb_led_pulse_code_encoder_top import rlpc_pkg::*; #(
  parameter int unsigned ScaleFracBits = SCALE_FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Pixel requests.
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic       last_pixel_i,
  // Duty-code results.
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] duty_code_o,
  output logic [7:0] repeat_count_o,
  output logic       frame_end_o,
  // Configuration writes.
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i
);

  // Configuration registers.
  logic       scale_en_q;
  logic [5:0] bright_q;
  logic [7:0] gap_slots_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_en_q  <= 1'b0;
      bright_q    <= MAX_ANGLE;
      gap_slots_q <= DEFAULT_GAP;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SCALE_ENABLE: scale_en_q  <= cfg_wdata_i[0];
        CFG_BRIGHTNESS:   bright_q    <= cfg_wdata_i[5:0];
        CFG_RESET_SLOTS:  gap_slots_q <= cfg_wdata_i;
        default: begin
          // Writes to an unused index are dropped.
        end
      endcase
    end
  end

  // A zero gap length is stretched to one slot.
  logic [7:0] gap_len;
  assign gap_len = (gap_slots_q == 8'd0) ? 8'd1 : gap_slots_q;

  // Input register. It refills in the same cycle that its pixel moves on.
  logic       a_valid_q;
  logic [7:0] a_red_q;
  logic [7:0] a_green_q;
  logic [7:0] a_blue_q;
  logic       a_last_q;
  logic       a_take;
  logic       in_take;
  ser_stat_t  ser_stat;

  assign a_take     = a_valid_q && ser_stat.free;
  assign in_ready_o = !a_valid_q || a_take;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_take) begin
      a_valid_q <= 1'b1;
    end else if (a_take) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_red_q   <= red_i;
      a_green_q <= green_i;
      a_blue_q  <= blue_i;
      a_last_q  <= last_pixel_i;
    end
  end

  // Brightness scaling: one multiplier per channel, all in parallel.
  logic [7:0] red_sc;
  logic [7:0] green_sc;
  logic [7:0] blue_sc;

  rlpc_scaler #(.ScaleFracBits(ScaleFracBits)) u_scale_red (
    .chan_i  (a_red_q),
    .bright_i(bright_q),
    .chan_o  (red_sc)
  );

  rlpc_scaler #(.ScaleFracBits(ScaleFracBits)) u_scale_green (
    .chan_i  (a_green_q),
    .bright_i(bright_q),
    .chan_o  (green_sc)
  );

  rlpc_scaler #(.ScaleFracBits(ScaleFracBits)) u_scale_blue (
    .chan_i  (a_blue_q),
    .bright_i(bright_q),
    .chan_o  (blue_sc)
  );

  // The word goes out most significant bit first in green, red, blue order.
  pixel_t pixel;
  assign pixel.color = scale_en_q ? {green_sc, red_sc, blue_sc}
                                  : {a_green_q, a_red_q, a_blue_q};
  assign pixel.last  = a_last_q;

  rlpc_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (a_take),
    .pixel_i       (pixel),
    .gap_len_i     (gap_len),
    .stat_o        (ser_stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .duty_code_o   (duty_code_o),
    .repeat_count_o(repeat_count_o),
    .frame_end_o   (frame_end_o)
  );

  // The gap result carries the gap code and a nonzero slot count.
  `RLPC_ASSERT_SAME(a_gap_fields, clk_i, rst_ni, out_valid_o && frame_end_o,
                    (duty_code_o == CODE_GAP) && (repeat_count_o != 8'd0),
                    "gap result has wrong code or count")

  // A data result is a one or zero code lasting a single slot.
  `RLPC_ASSERT_SAME(a_data_fields, clk_i, rst_ni, out_valid_o && !frame_end_o,
                    (repeat_count_o == 8'd1) &&
                    ((duty_code_o == CODE_ONE) || (duty_code_o == CODE_ZERO)),
                    "data result has wrong code or count")

  // The input only stalls with a pixel waiting in the input register.
  `RLPC_ASSERT_SAME(a_stall_cause, clk_i, rst_ni, !in_ready_o,
                    a_valid_q && ser_stat.busy,
                    "input stalled without a waiting pixel")

  // A waiting pixel follows the finished one without a bubble.
  `RLPC_ASSERT_NEXT(a_no_bubble, clk_i, rst_ni, a_take, out_valid_o,
                    "serializer idle after loading a pixel")

endmodule
